// ===== design/gpio_status_rule_evaluator_assert.svh =====
// Assertion macros for the GPIO status rule evaluator.
// Used by the top level; expects i_clk and i_rst_n in the including scope.
`ifndef GPIO_STATUS_RULE_EVALUATOR_ASSERT_SVH
`define GPIO_STATUS_RULE_EVALUATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define GSRE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define GSRE_ASSERT_NR(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define GSRE_ASSERT(lbl, prop, msg)
`define GSRE_ASSERT_NR(lbl, prop, msg)
`endif

`endif

// ===== design/gsre_pkg.sv =====
// Shared types and constants of the GPIO status rule evaluator.
// No dependencies; used by every module of the block.
package gsre_pkg;

    localparam int MAX_RULES_DEF     = 16;
    localparam int PROGRAM_DEPTH_DEF = 64;
    localparam int NUM_LINES_DEF     = 32;

    localparam logic [2:0] CFG_RULE_COUNT   = 3'd0;
    localparam logic [2:0] CFG_CHARGING     = 3'd1;
    localparam logic [2:0] CFG_DISCHARGING  = 3'd2;
    localparam logic [2:0] CFG_LOW_BATTERY  = 3'd3;
    localparam logic [2:0] CFG_BYPASS       = 3'd4;
    localparam logic [2:0] CFG_LOW_CHG_EN   = 3'd5;
    localparam logic [2:0] CFG_LOW_CHG_PCT  = 3'd6;

    localparam logic [4:0] RULE_NONE = 5'd16;
    localparam logic [6:0] PCT_FULL  = 7'd100;

    localparam logic [1:0] STATUS_UNKNOWN     = 2'd0;
    localparam logic [1:0] STATUS_CHARGING    = 2'd1;
    localparam logic [1:0] STATUS_DISCHARGING = 2'd2;

    typedef enum logic [1:0] {
        KIND_LINE   = 2'd0,
        KIND_INVERT = 2'd1,
        KIND_AND    = 2'd2,
        KIND_OR     = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic [4:0] rule_count;
        logic [4:0] charging_rule;
        logic [4:0] discharging_rule;
        logic [4:0] low_battery_rule;
        logic [4:0] bypass_rule;
        logic       low_charge_enable;
        logic [6:0] low_charge_percent;
    } t_cfg;

    // Program word layout: rule end in bit 7, line in bits 6..2, kind in bits 1..0.
    typedef struct packed {
        logic       ends_rule;
        logic [4:0] line;
        t_kind      kind;
    } t_word;

    typedef struct packed {
        logic        is_sample;
        logic        write_ok;
        logic [5:0]  addr;
        t_word       word;
        logic [31:0] lines;
    } t_cmd;

    typedef struct packed {
        logic [3:0] rule_index;
        logic       rule_valid;
        logic       rule_value;
        logic       rule_changed;
        logic [1:0] charger_status;
        logic       battery_low;
        logic       bypass_active;
        logic       charge_valid;
        logic [6:0] charge_percent;
        logic       last;
    } t_result;

endpackage

// ===== design/gpio_status_rule_evaluator.sv =====
// A program-write item is taken by the walker while it is idle; a sample passes ST_START
// and walks the program store word by word, at most PROGRAM_DEPTH words; each rule left
// after the store runs out still gives a result. The single read port of the store is
// walked one word a cycle, but a rule's last word waits while the output stalls. Results
// of one sample come out in rule order, one per rule, the last carrying the charger and
// battery summary; with no rules configured a single summary-only result is given.
module gpio_status_rule_evaluator #(
    parameter int MAX_RULES     = gsre_pkg::MAX_RULES_DEF,
    parameter int PROGRAM_DEPTH = gsre_pkg::PROGRAM_DEPTH_DEF,
    parameter int NUM_LINES     = gsre_pkg::NUM_LINES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_opcode,
    input  logic [5:0]  i_word_address,
    input  logic [1:0]  i_word_kind,
    input  logic [4:0]  i_word_line,
    input  logic        i_word_ends_rule,
    input  logic [31:0] i_line_states,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_rule_index,
    output logic        o_rule_valid,
    output logic        o_rule_value,
    output logic        o_rule_changed,
    output logic [1:0]  o_charger_status,
    output logic        o_battery_low,
    output logic        o_bypass_active,
    output logic        o_charge_valid,
    output logic [6:0]  o_charge_percent,
    output logic        o_last
);

`include "gpio_status_rule_evaluator_assert.svh"

    gsre_pkg::t_cfg    r_cfg;
    gsre_pkg::t_cfg    n_cfg;
    gsre_pkg::t_cmd    front_cmd;
    gsre_pkg::t_cmd    queue_cmd;
    gsre_pkg::t_result result;
    logic              front_vld;
    logic              front_rdy;
    logic              queue_vld;
    logic              queue_rdy;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                gsre_pkg::CFG_RULE_COUNT:  n_cfg.rule_count         = i_cfg_data[4:0];
                gsre_pkg::CFG_CHARGING:    n_cfg.charging_rule      = i_cfg_data[4:0];
                gsre_pkg::CFG_DISCHARGING: n_cfg.discharging_rule   = i_cfg_data[4:0];
                gsre_pkg::CFG_LOW_BATTERY: n_cfg.low_battery_rule   = i_cfg_data[4:0];
                gsre_pkg::CFG_BYPASS:      n_cfg.bypass_rule        = i_cfg_data[4:0];
                gsre_pkg::CFG_LOW_CHG_EN:  n_cfg.low_charge_enable  = i_cfg_data[0];
                gsre_pkg::CFG_LOW_CHG_PCT: n_cfg.low_charge_percent = i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rule_count         <= 5'd0;
            r_cfg.charging_rule      <= gsre_pkg::RULE_NONE;
            r_cfg.discharging_rule   <= gsre_pkg::RULE_NONE;
            r_cfg.low_battery_rule   <= gsre_pkg::RULE_NONE;
            r_cfg.bypass_rule        <= gsre_pkg::RULE_NONE;
            r_cfg.low_charge_enable  <= 1'b0;
            r_cfg.low_charge_percent <= 7'd0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    gsre_front #(
        .PROGRAM_DEPTH(PROGRAM_DEPTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_opcode        (i_opcode),
        .i_word_address  (i_word_address),
        .i_word_kind     (i_word_kind),
        .i_word_line     (i_word_line),
        .i_word_ends_rule(i_word_ends_rule),
        .i_line_states   (i_line_states),
        .o_cmd_valid     (front_vld),
        .i_cmd_ready     (front_rdy),
        .o_cmd           (front_cmd)
    );

    gsre_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(front_vld),
        .o_ready(front_rdy),
        .i_cmd  (front_cmd),
        .o_valid(queue_vld),
        .i_ready(queue_rdy),
        .o_cmd  (queue_cmd)
    );

    gsre_back #(
        .MAX_RULES    (MAX_RULES),
        .PROGRAM_DEPTH(PROGRAM_DEPTH),
        .NUM_LINES    (NUM_LINES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_cmd_valid(queue_vld),
        .o_cmd_ready(queue_rdy),
        .i_cmd      (queue_cmd),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_result   (result)
    );

    assign o_rule_index     = result.rule_index;
    assign o_rule_valid     = result.rule_valid;
    assign o_rule_value     = result.rule_value;
    assign o_rule_changed   = result.rule_changed;
    assign o_charger_status = result.charger_status;
    assign o_battery_low    = result.battery_low;
    assign o_bypass_active  = result.bypass_active;
    assign o_charge_valid   = result.charge_valid;
    assign o_charge_percent = result.charge_percent;
    assign o_last           = result.last;

    `GSRE_ASSERT_NR(a_reset_clears_out, !i_rst_n |=> !o_valid, "result valid after reset")
    `GSRE_ASSERT(a_summary_only_last, o_valid && !o_last |-> o_charger_status == 2'd0 && o_charge_percent == 7'd0 && !o_battery_low && !o_bypass_active, "summary on non-final result")
    `GSRE_ASSERT(a_no_rule_is_last, o_valid && !o_rule_valid |-> o_last && !o_rule_changed, "summary-only result not final")
    `GSRE_ASSERT(a_queue_feeds_idle_walker, queue_vld && queue_rdy && queue_cmd.is_sample |=> !queue_rdy, "walker took a sample without leaving idle")

endmodule

// ===== design/gsre_front.sv =====
// Front end: accepts items and classifies them into store writes and samples.
// Depends on gsre_pkg.
module gsre_front #(
    parameter int PROGRAM_DEPTH = gsre_pkg::PROGRAM_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_opcode,
    input  logic [5:0]       i_word_address,
    input  logic [1:0]       i_word_kind,
    input  logic [4:0]       i_word_line,
    input  logic             i_word_ends_rule,
    input  logic [31:0]      i_line_states,
    output logic             o_cmd_valid,
    input  logic             i_cmd_ready,
    output gsre_pkg::t_cmd   o_cmd
);

    logic           r_vld;
    logic           n_vld;
    gsre_pkg::t_cmd r_cmd;
    gsre_pkg::t_cmd n_cmd;
    logic           accept;

    assign o_stall     = r_vld && !i_cmd_ready;
    assign accept      = i_valid && !o_stall;
    assign o_cmd_valid = r_vld;
    assign o_cmd       = r_cmd;

    always_comb begin
        n_vld = accept || (r_vld && !i_cmd_ready);
        n_cmd = r_cmd;
        if (accept) begin
            n_cmd.is_sample      = i_opcode;
            n_cmd.write_ok       = 32'(i_word_address) < PROGRAM_DEPTH;
            n_cmd.addr           = i_word_address;
            n_cmd.word.ends_rule = i_word_ends_rule;
            n_cmd.word.line      = i_word_line;
            n_cmd.word.kind      = gsre_pkg::t_kind'(i_word_kind);
            n_cmd.lines          = i_line_states;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

endmodule

// ===== design/gsre_queue.sv =====
// Two-entry queue that decouples the front end from the rule walker.
// Depends on gsre_pkg.
module gsre_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  gsre_pkg::t_cmd i_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output gsre_pkg::t_cmd o_cmd
);

    gsre_pkg::t_cmd r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic           n_wr_ptr;
    logic           n_rd_ptr;
    logic [1:0]     n_count;
    logic           push;
    logic           pop;

    assign o_ready = r_count != 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_cmd   = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wr_ptr = push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== design/gsre_back.sv =====
// Back end: program store, rule walker and result register.
// Depends on gsre_pkg; fed by gsre_queue, configured from the top level.
module gsre_back #(
    parameter int MAX_RULES     = gsre_pkg::MAX_RULES_DEF,
    parameter int PROGRAM_DEPTH = gsre_pkg::PROGRAM_DEPTH_DEF,
    parameter int NUM_LINES     = gsre_pkg::NUM_LINES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gsre_pkg::t_cfg    i_cfg,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    input  gsre_pkg::t_cmd    i_cmd,
    output logic              o_valid,
    input  logic              i_stall,
    output gsre_pkg::t_result o_result
);

    localparam int AW = $clog2(PROGRAM_DEPTH);
    localparam int RW = $clog2(MAX_RULES + 1);
    localparam int IW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;

    logic [7:0]          r_store [PROGRAM_DEPTH];
    logic [7:0]          r_word;
    logic                r_word_vld;
    logic                n_word_vld;
    logic [AW:0]         r_rd_addr;
    logic [AW:0]         n_rd_addr;
    logic                rd_en;
    logic                wr_en;
    logic [AW+5:0]       wr_addr_ext;

    gsre_pkg::t_state    r_state;
    gsre_pkg::t_state    n_state;
    logic [31:0]         r_lines;
    logic [31:0]         n_lines;
    logic [IW-1:0]       r_rule;
    logic [IW-1:0]       n_rule;
    logic                r_acc, r_term, r_has, r_inv;
    logic                n_acc, n_term, n_has, n_inv;
    logic                r_ch, r_dc, r_bl, r_bp;
    logic                n_ch, n_dc, n_bl, n_bp;
    logic [MAX_RULES-1:0] r_prev;
    logic [MAX_RULES-1:0] n_prev;
    logic                r_first_done;
    logic                n_first_done;
    logic                r_o_vld;
    logic                n_o_vld;
    gsre_pkg::t_result   r_o;
    gsre_pkg::t_result   n_o;

    gsre_pkg::t_word     w;
    logic [RW-1:0]       n_eff;
    logic                out_free;
    logic                lit_bit;
    logic                c_acc, c_term, c_has, c_inv;
    logic                done;
    logic                val;
    logic                advance;
    logic                last_rule;
    logic                f_ch, f_dc, f_bl, f_bp;
    logic [IW+3:0]       rule_ext;

    function automatic gsre_pkg::t_result mk_summary(
        input gsre_pkg::t_cfg cfg,
        input logic ch,
        input logic dc,
        input logic bl,
        input logic bp
    );
        gsre_pkg::t_result res;
        res = '0;
        if (ch && dc) begin
            res.charger_status = (cfg.discharging_rule >= cfg.charging_rule) ?
                gsre_pkg::STATUS_DISCHARGING : gsre_pkg::STATUS_CHARGING;
        end else if (ch) begin
            res.charger_status = gsre_pkg::STATUS_CHARGING;
        end else if (dc) begin
            res.charger_status = gsre_pkg::STATUS_DISCHARGING;
        end else begin
            res.charger_status = gsre_pkg::STATUS_UNKNOWN;
        end
        res.battery_low   = bl;
        res.bypass_active = bp;
        res.charge_valid  = cfg.low_charge_enable && !bp;
        if (res.charge_valid) begin
            if (bl) begin
                res.charge_percent = (cfg.low_charge_percent > gsre_pkg::PCT_FULL) ?
                    gsre_pkg::PCT_FULL : cfg.low_charge_percent;
            end else begin
                res.charge_percent = gsre_pkg::PCT_FULL;
            end
        end
        res.last = 1'b1;
        return res;
    endfunction

    assign o_valid     = r_o_vld;
    assign o_result    = r_o;
    assign o_cmd_ready = r_state == gsre_pkg::ST_IDLE;
    assign out_free    = !r_o_vld || !i_stall;
    assign n_eff       = (32'(i_cfg.rule_count) > MAX_RULES) ? RW'(MAX_RULES)
                                                              : RW'(i_cfg.rule_count);
    assign w           = gsre_pkg::t_word'(r_word);
    assign lit_bit     = (32'(w.line) < NUM_LINES) ? r_lines[w.line] : 1'b0;
    assign wr_en       = o_cmd_ready && i_cmd_valid && !i_cmd.is_sample && i_cmd.write_ok;
    assign wr_addr_ext = (AW + 6)'(i_cmd.addr);
    assign rule_ext    = (IW + 4)'(r_rule);

    // Evaluation of the word at the head of the walk.
    always_comb begin
        c_acc  = r_acc;
        c_term = r_term;
        c_has  = r_has;
        c_inv  = r_inv;
        if (r_word_vld) begin
            case (w.kind)
                gsre_pkg::KIND_LINE: begin
                    c_term = r_term & (lit_bit ^ r_inv);
                    c_has  = 1'b1;
                    c_inv  = 1'b0;
                end
                gsre_pkg::KIND_INVERT: begin
                    c_inv = 1'b1;
                end
                gsre_pkg::KIND_OR: begin
                    c_acc  = r_acc | (r_has & r_term);
                    c_term = 1'b1;
                    c_has  = 1'b0;
                    c_inv  = 1'b0;
                end
                default: begin
                end
            endcase
        end
        done      = !r_word_vld || w.ends_rule || (32'(r_rd_addr) >= PROGRAM_DEPTH);
        val       = c_acc | (c_has & c_term);
        advance   = !done || out_free;
        last_rule = (32'(r_rule) + 32'd1) == 32'(n_eff);
        f_ch      = r_ch || (val && (32'(r_rule) == 32'(i_cfg.charging_rule)));
        f_dc      = r_dc || (val && (32'(r_rule) == 32'(i_cfg.discharging_rule)));
        f_bl      = r_bl || (val && (32'(r_rule) == 32'(i_cfg.low_battery_rule)));
        f_bp      = r_bp || (val && (32'(r_rule) == 32'(i_cfg.bypass_rule)));
    end

    always_comb begin
        n_state      = r_state;
        n_lines      = r_lines;
        n_rule       = r_rule;
        n_acc        = r_acc;
        n_term       = r_term;
        n_has        = r_has;
        n_inv        = r_inv;
        n_ch         = r_ch;
        n_dc         = r_dc;
        n_bl         = r_bl;
        n_bp         = r_bp;
        n_prev       = r_prev;
        n_first_done = r_first_done;
        n_word_vld   = r_word_vld;
        n_rd_addr    = r_rd_addr;
        rd_en        = 1'b0;
        n_o_vld      = r_o_vld && i_stall;
        n_o          = r_o;
        case (r_state)
            gsre_pkg::ST_IDLE: begin
                if (i_cmd_valid && i_cmd.is_sample) begin
                    n_lines   = i_cmd.lines;
                    n_rd_addr = '0;
                    n_state   = gsre_pkg::ST_START;
                end
            end
            gsre_pkg::ST_START: begin
                n_rule = '0;
                n_acc  = 1'b0;
                n_term = 1'b1;
                n_has  = 1'b0;
                n_inv  = 1'b0;
                n_ch   = 1'b0;
                n_dc   = 1'b0;
                n_bl   = 1'b0;
                n_bp   = 1'b0;
                if (n_eff != '0) begin
                    rd_en      = 1'b1;
                    n_word_vld = 1'b1;
                    n_rd_addr  = (AW + 1)'(1);
                    n_state    = gsre_pkg::ST_RUN;
                end else if (out_free) begin
                    n_o_vld      = 1'b1;
                    n_o          = mk_summary(i_cfg, 1'b0, 1'b0, 1'b0, 1'b0);
                    n_first_done = 1'b1;
                    n_state      = gsre_pkg::ST_IDLE;
                end
            end
            gsre_pkg::ST_RUN: begin
                if (advance) begin
                    if (r_word_vld) begin
                        if (32'(r_rd_addr) < PROGRAM_DEPTH) begin
                            rd_en     = 1'b1;
                            n_rd_addr = r_rd_addr + 1'b1;
                        end else begin
                            n_word_vld = 1'b0;
                        end
                    end
                    if (done) begin
                        n_acc  = 1'b0;
                        n_term = 1'b1;
                        n_has  = 1'b0;
                        n_inv  = 1'b0;
                        n_ch   = f_ch;
                        n_dc   = f_dc;
                        n_bl   = f_bl;
                        n_bp   = f_bp;
                        n_o_vld = 1'b1;
                        n_o     = '0;
                        if (last_rule) begin
                            n_o          = mk_summary(i_cfg, f_ch, f_dc, f_bl, f_bp);
                            n_first_done = 1'b1;
                            n_state      = gsre_pkg::ST_IDLE;
                        end
                        n_o.rule_index   = rule_ext[3:0];
                        n_o.rule_valid   = 1'b1;
                        n_o.rule_value   = val;
                        n_o.rule_changed = r_first_done && (r_prev[r_rule] != val);
                        n_prev[r_rule]   = val;
                        n_rule           = r_rule + 1'b1;
                    end else begin
                        n_acc  = c_acc;
                        n_term = c_term;
                        n_has  = c_has;
                        n_inv  = c_inv;
                    end
                end
            end
            default: begin
                n_state = gsre_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= gsre_pkg::ST_IDLE;
            r_prev       <= '0;
            r_first_done <= 1'b0;
            r_o_vld      <= 1'b0;
            r_word_vld   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_prev       <= n_prev;
            r_first_done <= n_first_done;
            r_o_vld      <= n_o_vld;
            r_word_vld   <= n_word_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lines   <= n_lines;
        r_rule    <= n_rule;
        r_acc     <= n_acc;
        r_term    <= n_term;
        r_has     <= n_has;
        r_inv     <= n_inv;
        r_ch      <= n_ch;
        r_dc      <= n_dc;
        r_bl      <= n_bl;
        r_bp      <= n_bp;
        r_rd_addr <= n_rd_addr;
        r_o       <= n_o;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_addr_ext[AW-1:0]] <= i_cmd.word;
        end
        if (rd_en) begin
            r_word <= r_store[r_rd_addr[AW-1:0]];
        end
    end

endmodule
